// ===== sv/mavg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, types and divider constants of the moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // Window length in samples (1 to 256)
    localparam int WINDOW_LEN = 16;

    localparam int SAMPLE_W = 16;
    localparam int LEN_LOG  = $clog2(WINDOW_LEN);
    // Ring pointer needs at least one bit, even for a unit window
    localparam int PTR_W    = (WINDOW_LEN > 1) ? LEN_LOG : 1;
    // Exact sum of WINDOW_LEN signed samples
    localparam int SUM_W    = SAMPLE_W + LEN_LOG;

    // Division by WINDOW_LEN as multiply by a rounded-up reciprocal.
    // With a shift of SUM_W + LEN_LOG the quotient is exact for every
    // magnitude below 2**SUM_W.
    localparam int    DIV_SHIFT = SUM_W + LEN_LOG;
    localparam longint DIV_MULT =
        ((longint'(1) << DIV_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
    localparam int MULT_W = SUM_W + 1;
    localparam int PROD_W = SUM_W + MULT_W;
    // Quotient magnitude reaches 2**(SAMPLE_W-1) for the most negative mean
    localparam int QUOT_W = SAMPLE_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [PTR_W-1:0]           ptr_t;
    typedef logic [PROD_W-1:0]          prod_t;

    // Window sum handed from the window stage to the divider
    typedef struct packed {
        logic valid;
        sum_t sum;
    } sum_item_t;

endpackage : mavg_pkg
`default_nettype wire

// ===== sv/mavg_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_sample_if
// Valid/ready channel that carries one input sample per item.
// ----------------------------------------------------------------------------
interface mavg_sample_if;
    import mavg_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface : mavg_sample_if
`default_nettype wire

// ===== sv/mavg_average_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_average_if
// Valid/ready channel that carries one windowed mean per item.
// ----------------------------------------------------------------------------
interface mavg_average_if;
    import mavg_pkg::*;

    logic    valid;
    logic    ready;
    sample_t average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface : mavg_average_if
`default_nettype wire

// ===== sv/mavg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: the read samples the array before this edge's write lands
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule : mavg_ram
`default_nettype wire

// ===== sv/mavg_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_window
// Ring buffer of the last WINDOW_LEN samples and the running window sum.
// Each accepted item after the first reads the oldest entry and overwrites
// it in the same cycle; stage 1 holds it until the running sum takes it.
// ----------------------------------------------------------------------------
module mavg_window (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mavg_sample_if.sink        sample_ch,
    output mavg_pkg::sum_item_t sum_item,
    input  wire logic          sum_ready
);
    import mavg_pkg::*;

    // Accept-side state
    logic    primed_reg;   // first sample seen
    logic    lap_reg;      // every ring entry written at least once
    ptr_t    ptr_reg;      // oldest entry
    sample_t first_reg;    // first sample, stands in for unwritten entries

    // Stage 1: sample waiting for its old entry from the RAM
    logic    s1_valid_reg;
    logic    s1_first_reg;
    logic    s1_use_ram_reg;
    sample_t s1_sample_reg;

    // Running sum doubles as the output register
    logic    sum_valid_reg;
    sum_t    sum_reg;

    logic    accept;
    logic    s1_ready;
    logic    s1_move;
    logic    ring_write;
    sample_t old_data;
    sample_t old_entry;
    sum_t    sum_next;

    assign s1_ready        = !sum_valid_reg || sum_ready;
    assign s1_move         = s1_valid_reg && s1_ready;
    assign sample_ch.ready = !s1_valid_reg || s1_ready;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign ring_write      = accept && primed_reg;

    // Window storage
    mavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (ring_write),
        .waddr (ptr_reg),
        .wdata (sample_ch.sample),
        .re    (ring_write),
        .raddr (ptr_reg),
        .rdata (old_data)
    );

    // Until the ring has wrapped once, the oldest entry is the first sample
    assign old_entry = s1_use_ram_reg ? old_data : first_reg;

    // Sum update
    always_comb
    begin
        if (s1_first_reg)
        begin
            sum_next = SUM_W'(s1_sample_reg) * SUM_W'(WINDOW_LEN);
        end
        else
        begin
            sum_next = sum_reg - SUM_W'(old_entry) + SUM_W'(s1_sample_reg);
        end
    end

    // Ring pointer, fill tracking and stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            lap_reg        <= 1'b0;
            ptr_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_use_ram_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_first_reg   <= !primed_reg;
                s1_use_ram_reg <= lap_reg;
                if (!primed_reg)
                begin
                    primed_reg <= 1'b1;
                end
                else if (ptr_reg == PTR_W'(WINDOW_LEN - 1))
                begin
                    ptr_reg <= '0;
                    lap_reg <= 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_ch.sample;
            if (!primed_reg)
            begin
                first_reg <= sample_ch.sample;
            end
        end
    end

    // Running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (s1_move)
            begin
                sum_reg       <= sum_next;
                sum_valid_reg <= 1'b1;
            end
            else if (sum_ready)
            begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    assign sum_item.valid = sum_valid_reg;
    assign sum_item.sum   = sum_reg;

    // Checks
    a_lap_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
        lap_reg |-> primed_reg)
        else $error("ring marked full before the first sample");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(WINDOW_LEN - 1))
        else $error("ring pointer beyond window");

    a_first_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !primed_reg) |-> (ptr_reg == '0) && !lap_reg)
        else $error("first sample with ring already advanced");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_ready) |=> s1_valid_reg && $stable(s1_sample_reg)
                                        && $stable(sum_reg))
        else $error("stalled item lost in window stage");

endmodule : mavg_window
`default_nettype wire

// ===== sv/mavg_divide.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_divide
// Divides the window sum by WINDOW_LEN, truncating toward zero: magnitude
// times reciprocal in one stage, shift and sign restore into the output
// register in the next.
// ----------------------------------------------------------------------------
module mavg_divide (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mavg_pkg::sum_item_t sum_item,
    output logic                sum_ready,
    mavg_average_if.source      average_ch
);
    import mavg_pkg::*;

    localparam logic [MULT_W-1:0] RECIP = MULT_W'(DIV_MULT);

    logic              p_valid_reg;
    logic              p_neg_reg;
    prod_t             p_prod_reg;
    logic              out_valid_reg;
    sample_t           average_reg;

    logic              p_ready;
    logic              sum_neg;
    logic [SUM_W-1:0]  sum_mag;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] quot_signed;

    assign p_ready   = !out_valid_reg || average_ch.ready;
    assign sum_ready = !p_valid_reg || p_ready;

    // Magnitude of the sum
    assign sum_neg = sum_item.sum[SUM_W-1];
    assign sum_mag = sum_neg ? (~sum_item.sum + 1'b1) : sum_item.sum;

    // Quotient and sign restore
    assign quot        = QUOT_W'(p_prod_reg >> DIV_SHIFT);
    assign quot_signed = p_neg_reg ? (~quot + 1'b1) : quot;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_ready)
            begin
                p_valid_reg <= sum_item.valid;
            end
            if (p_ready)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (sum_ready && sum_item.valid)
        begin
            p_neg_reg  <= sum_neg;
            p_prod_reg <= PROD_W'(sum_mag) * PROD_W'(RECIP);
        end
        if (p_ready && p_valid_reg)
        begin
            average_reg <= sample_t'(quot_signed[SAMPLE_W-1:0]);
        end
    end

    assign average_ch.valid   = out_valid_reg;
    assign average_ch.average = average_reg;

endmodule : mavg_divide
`default_nettype wire

// ===== sv/moving_average_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar mean over the last WINDOW_LEN signed 16-bit samples.
// ----------------------------------------------------------------------------
// Takes one sample item per clock while the output does not stall and
// returns one registered average item per sample, in order. The rate of one item
// per cycle is set by the window RAM: each item reads its oldest entry and
// overwrites it in the same cycle on one read-first port, and the running
// sum absorbs one item per cycle. The divider is a constant-reciprocal
// multiply with its own register stage. Backpressure on the output stalls
// each stage only when the stage after it is full, so bubbles are squeezed
// out. The first sample after reset passes through and stands for every
// window entry until the ring has wrapped; there is no clearing pass.
// ----------------------------------------------------------------------------
module moving_average_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mavg_sample_if.sink      sample_ch,
    mavg_average_if.source   average_ch
);
    import mavg_pkg::*;

    sum_item_t sum_item;
    logic      sum_ready;

    // Ring buffer and running sum
    mavg_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .sum_item  (sum_item),
        .sum_ready (sum_ready)
    );

    // Divide by window length
    mavg_divide u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_item   (sum_item),
        .sum_ready  (sum_ready),
        .average_ch (average_ch)
    );

endmodule : moving_average_filter
`default_nettype wire
